@@ design/mfbpw_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the monochrome framebuffer pixel writer
package mfbpw_pkg;

    localparam int COORD_W    = 9;
    localparam int DIM_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int OUT_ADDR_W = 13;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_PIXEL = 2'd0;
    localparam t_op OP_FILL  = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam t_cfg_idx CFG_WIDTH    = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT   = 2'd1;
    localparam t_cfg_idx CFG_ROTATION = 2'd2;
    localparam t_cfg_idx CFG_REVERSED = 2'd3;

    localparam t_byte BYTE_TOP_BIT = 8'h80;
    localparam t_byte BYTE_ONES    = 8'hff;
    localparam t_byte BYTE_ZERO    = 8'h00;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 10'd256;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 10'd128;

endpackage

@@ design/mfbpw_ram.sv @@
`timescale 1ns / 1ps
// generic single-port ram with registered read
module mfbpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mono_framebuffer_pixel_writer_top.sv @@
`timescale 1ns / 1ps
// monochrome framebuffer pixel writer, top level
// pixel write: rotate, address calc, read, write back, then the result word;
// dropped pixel: no write back, written low; unused op: written low as well
// fill and clear: one byte per cycle over all FB_BYTES bytes, then the result
// word; a new input is taken only once the last result word is registered
// reset: registers to defaults, then a clearing pass over all FB_BYTES bytes
// with input ready low; configuration writes are taken in every state
module mono_framebuffer_pixel_writer_top #(
    parameter int FB_BYTES = 8192,
    parameter int MAX_DIM  = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mfbpw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfbpw_pkg::DIM_W-1:0]        i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // x[8:0], y[17:9], color[18], fill_byte[26:19], zero pad
    input  logic [mfbpw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [mfbpw_pkg::OP_W-1:0]         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // byte_addr[12:0], byte_value[20:13], zero pad
    output logic [mfbpw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // written[0]
    output logic                               m_axis_tuser
);

    localparam int AW = $clog2(FB_BYTES);
    localparam logic [31:0] FB_LIM    = 32'(FB_BYTES);
    localparam logic [AW-1:0] LAST_IX = AW'(FB_BYTES - 1);
    localparam logic [10:0] MAX_DIM_W = 11'(MAX_DIM);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOC  = 3'd2;
    localparam logic [2:0] S_ADDR = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]                         r_state;
    logic [mfbpw_pkg::DIM_W-1:0]        r_width;
    logic [mfbpw_pkg::DIM_W-1:0]        r_height;
    logic [1:0]                         r_rotation;
    logic                               r_reversed;

    logic [mfbpw_pkg::COORD_W-1:0]      r_x;
    logic [mfbpw_pkg::COORD_W-1:0]      r_y;
    logic                               r_color;
    mfbpw_pkg::t_byte                   r_fill_val;
    logic [AW-1:0]                      r_sweep;

    logic [mfbpw_pkg::DIM_W-1:0]        r_col;
    logic [mfbpw_pkg::DIM_W-1:0]        r_ry;
    logic                               r_hit;
    logic [AW-1:0]                      r_addr;
    mfbpw_pkg::t_byte                   r_mask;

    logic [mfbpw_pkg::OUT_ADDR_W-1:0]   r_res_addr;
    mfbpw_pkg::t_byte                   r_res_val;
    logic                               r_res_wr;

    logic                               r_out_valid;
    logic [mfbpw_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic                               r_out_user;

    logic                               in_acc;
    logic [mfbpw_pkg::DIM_W-1:0]        w_c;
    logic [mfbpw_pkg::DIM_W-1:0]        h_c;
    logic signed [11:0]                 sw;
    logic signed [11:0]                 sh;
    logic signed [11:0]                 sx;
    logic signed [11:0]                 sy;
    logic signed [11:0]                 rx;
    logic signed [11:0]                 ry;
    logic                               loc_hit;
    logic [mfbpw_pkg::DIM_W-1:0]        loc_col;
    logic [16:0]                        prod;
    logic [17:0]                        off;
    logic                               off_ok;
    logic [31:0]                        addr_ext;

    logic                               ram_we;
    logic [AW-1:0]                      ram_addr;
    mfbpw_pkg::t_byte                   ram_wdata;
    mfbpw_pkg::t_byte                   ram_rdata;
    mfbpw_pkg::t_byte                   n_byte;

    mfbpw_ram #(
        .WIDTH (mfbpw_pkg::BYTE_W),
        .DEPTH (FB_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // clamped panel size
    assign w_c = ({1'b0, r_width} > MAX_DIM_W) ? MAX_DIM_W[9:0] : r_width;
    assign h_c = ({1'b0, r_height} > MAX_DIM_W) ? MAX_DIM_W[9:0] : r_height;

    // rotation and range check
    always_comb begin
        sw = $signed({2'b00, w_c});
        sh = $signed({2'b00, h_c});
        sx = $signed({3'b000, r_x});
        sy = $signed({3'b000, r_y});
        case (r_rotation)
            2'd1: begin
                rx = sw - 12'sd1 - sy;
                ry = sx;
            end
            2'd2: begin
                rx = sw - 12'sd1 - sx;
                ry = sh - 12'sd1 - sy;
            end
            2'd3: begin
                rx = sy;
                ry = sh - 12'sd1 - sx;
            end
            default: begin
                rx = sx;
                ry = sy;
            end
        endcase
        loc_hit = (w_c != '0) && (h_c != '0) && (rx >= 12'sd0) && (rx < sw)
                  && (ry >= 12'sd0) && (ry < sh);
        loc_col = (rx == 12'sd0) ? '0 : (w_c - rx[9:0]);
    end

    // byte offset
    assign prod     = r_col * h_c[9:3];
    assign off      = 18'(prod) + 18'(r_ry[9:3]);
    assign off_ok   = (32'(off) < FB_LIM);
    assign addr_ext = 32'(r_addr);

    assign n_byte = (r_color ^ r_reversed) ? (ram_rdata | r_mask)
                                           : (ram_rdata & ~r_mask);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = n_byte;
        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep;
                ram_wdata = mfbpw_pkg::BYTE_ZERO;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep;
                ram_wdata = r_fill_val;
            end
            S_ADDR: begin
                ram_addr = off[AW-1:0];
            end
            S_MOD: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
            r_width     <= mfbpw_pkg::WIDTH_RST;
            r_height    <= mfbpw_pkg::HEIGHT_RST;
            r_rotation  <= 2'd0;
            r_reversed  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    mfbpw_pkg::CFG_WIDTH:    r_width    <= i_cfg_data;
                    mfbpw_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data;
                    mfbpw_pkg::CFG_ROTATION: r_rotation <= i_cfg_data[1:0];
                    mfbpw_pkg::CFG_REVERSED: r_reversed <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == LAST_IX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_x     <= s_axis_tdata[8:0];
                        r_y     <= s_axis_tdata[17:9];
                        r_color <= s_axis_tdata[18];
                        r_sweep <= '0;
                        case (s_axis_tuser)
                            mfbpw_pkg::OP_PIXEL: begin
                                r_state <= S_LOC;
                            end
                            mfbpw_pkg::OP_FILL: begin
                                r_fill_val <= s_axis_tdata[26:19];
                                r_state    <= S_FILL;
                            end
                            mfbpw_pkg::OP_CLEAR: begin
                                r_fill_val <= r_reversed ? mfbpw_pkg::BYTE_ONES
                                                         : mfbpw_pkg::BYTE_ZERO;
                                r_state    <= S_FILL;
                            end
                            default: begin
                                r_res_addr <= '0;
                                r_res_val  <= mfbpw_pkg::BYTE_ZERO;
                                r_res_wr   <= 1'b0;
                                r_state    <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_LOC: begin
                    r_hit   <= loc_hit;
                    r_col   <= loc_col;
                    r_ry    <= ry[9:0];
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    if (r_hit && off_ok) begin
                        r_addr  <= off[AW-1:0];
                        r_mask  <= mfbpw_pkg::BYTE_TOP_BIT >> r_ry[2:0];
                        r_state <= S_MOD;
                    end else begin
                        r_res_addr <= '0;
                        r_res_val  <= mfbpw_pkg::BYTE_ZERO;
                        r_res_wr   <= 1'b0;
                        r_state    <= S_EMIT;
                    end
                end
                S_MOD: begin
                    r_res_addr <= addr_ext[mfbpw_pkg::OUT_ADDR_W-1:0];
                    r_res_val  <= n_byte;
                    r_res_wr   <= 1'b1;
                    r_state    <= S_EMIT;
                end
                S_FILL: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == LAST_IX) begin
                        r_res_addr <= '0;
                        r_res_val  <= r_fill_val;
                        r_res_wr   <= 1'b1;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b000, r_res_val, r_res_addr};
                        r_out_user  <= r_res_wr;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ test/tb_mono_framebuffer_pixel_writer_top.sv @@
`timescale 1ns / 1ps
// testbench for the framebuffer pixel writer: stream driver, shadow framebuffer and result check
module tb_mono_framebuffer_pixel_writer_top;

    localparam int FB_BYTES       = 8192;
    localparam int MAX_DIM        = 512;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 40000;

    localparam mfbpw_pkg::t_op OP_NONE = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        mfbpw_pkg::t_op                op;
        logic [mfbpw_pkg::COORD_W-1:0] x;
        logic [mfbpw_pkg::COORD_W-1:0] y;
        logic                          color;
        mfbpw_pkg::t_byte              fill;
    } t_draw_cmd;

    typedef struct packed {
        logic [mfbpw_pkg::OUT_ADDR_W-1:0] addr;
        mfbpw_pkg::t_byte                 value;
        logic                             written;
    } t_byte_update;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    mfbpw_pkg::t_cfg_idx               i_cfg_index = mfbpw_pkg::CFG_WIDTH;
    logic [mfbpw_pkg::DIM_W-1:0]       i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [mfbpw_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    mfbpw_pkg::t_op                    s_axis_tuser = mfbpw_pkg::OP_PIXEL;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [mfbpw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              m_axis_tuser;

    // shadow of the panel registers and the framebuffer
    logic [mfbpw_pkg::DIM_W-1:0] cfg_width = mfbpw_pkg::WIDTH_RST;
    logic [mfbpw_pkg::DIM_W-1:0] cfg_height = mfbpw_pkg::HEIGHT_RST;
    logic [1:0]       cfg_rot = ROT_0;
    logic             cfg_rev = 1'b0;
    bit [7:0]         fb_image [FB_BYTES];

    t_draw_cmd    cmd_q[$];
    t_byte_update update_q[$];
    t_draw_cmd    cur_cmd;
    t_byte_update seen_upd;
    t_byte_update want_upd;
    logic [mfbpw_pkg::COORD_W-1:0] last_x = '0;
    logic [mfbpw_pkg::COORD_W-1:0] last_y = '0;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int mismatch_cnt = 0;
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    mono_framebuffer_pixel_writer_top #(
        .FB_BYTES(FB_BYTES),
        .MAX_DIM (MAX_DIM)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_byte_update apply_cmd(input t_draw_cmd c);
        t_byte_update r;
        int w, h, xi, yi, rx, ry, col, off;
        mfbpw_pkg::t_byte fill_v, mask;
        r = '0;
        if (c.op == mfbpw_pkg::OP_PIXEL) begin
            w = cfg_width;
            h = cfg_height;
            if (w > MAX_DIM) w = MAX_DIM;
            if (h > MAX_DIM) h = MAX_DIM;
            xi = c.x;
            yi = c.y;
            case (cfg_rot)
                ROT_90: begin
                    rx = w - 1 - yi;
                    ry = xi;
                end
                ROT_180: begin
                    rx = w - 1 - xi;
                    ry = h - 1 - yi;
                end
                ROT_270: begin
                    rx = yi;
                    ry = h - 1 - xi;
                end
                default: begin
                    rx = xi;
                    ry = yi;
                end
            endcase
            if (w != 0 && h != 0 && rx >= 0 && rx < w && ry >= 0 && ry < h) begin
                // column is mirrored on the panel
                col = (w - rx) % w;
                off = ry / 8 + col * (h / 8);
                if (off < FB_BYTES) begin
                    mask = mfbpw_pkg::BYTE_TOP_BIT >> ry[2:0];
                    if (c.color ^ cfg_rev) begin
                        fb_image[off] = fb_image[off] | mask;
                    end else begin
                        fb_image[off] = fb_image[off] & ~mask;
                    end
                    r.addr = off[mfbpw_pkg::OUT_ADDR_W-1:0];
                    r.value = fb_image[off];
                    r.written = 1'b1;
                end
            end
        end else if (c.op == mfbpw_pkg::OP_FILL || c.op == mfbpw_pkg::OP_CLEAR) begin
            fill_v = (c.op == mfbpw_pkg::OP_FILL) ? c.fill
                   : (cfg_rev ? mfbpw_pkg::BYTE_ONES : mfbpw_pkg::BYTE_ZERO);
            foreach (fb_image[i]) fb_image[i] = fill_v;
            r.value = fill_v;
            r.written = 1'b1;
        end
        return r;
    endfunction

    function automatic t_draw_cmd random_cmd();
        t_draw_cmd c;
        int pick, span;
        c.op = mfbpw_pkg::OP_PIXEL;
        c.x = 9'($urandom_range(511));
        c.y = 9'($urandom_range(511));
        c.color = 1'($urandom_range(1));
        c.fill = 8'($urandom_range(255));
        pick = $urandom_range(999);
        if (pick < 5) begin
            c.op = mfbpw_pkg::OP_FILL;
        end else if (pick < 10) begin
            c.op = mfbpw_pkg::OP_CLEAR;
        end else if (pick < 20) begin
            c.op = OP_NONE;
        end else begin
            span = (cfg_width > cfg_height) ? cfg_width : cfg_height;
            if (span == 0 || span > 511) span = 511;
            pick = $urandom_range(99);
            // neighbours of the last pixel come back to back, with only the low three bits of y or x new
            if (pick < 30) begin
                c.x = last_x;
                c.y = {last_y[mfbpw_pkg::COORD_W-1:3], 3'($urandom_range(7))};
            end else if (pick < 40) begin
                c.x = {last_x[mfbpw_pkg::COORD_W-1:3], 3'($urandom_range(7))};
                c.y = last_y;
            end else if (pick < 85) begin
                c.x = 9'($urandom_range(span));
                c.y = 9'($urandom_range(span));
            end
            last_x = c.x;
            last_y = c.y;
        end
        return c;
    endfunction

    task automatic push_cmd(input mfbpw_pkg::t_op op, input logic [mfbpw_pkg::COORD_W-1:0] x,
                            input logic [mfbpw_pkg::COORD_W-1:0] y, input logic color,
                            input mfbpw_pkg::t_byte fill);
        t_draw_cmd c;
        c.op = op;
        c.x = x;
        c.y = y;
        c.color = color;
        c.fill = fill;
        cmd_q.push_back(c);
    endtask

    task automatic write_reg(input mfbpw_pkg::t_cfg_idx idx,
                             input logic [mfbpw_pkg::DIM_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mfbpw_pkg::CFG_WIDTH:    cfg_width = val;
            mfbpw_pkg::CFG_HEIGHT:   cfg_height = val;
            mfbpw_pkg::CFG_ROTATION: cfg_rot = val[1:0];
            mfbpw_pkg::CFG_REVERSED: cfg_rev = val[0];
            default:      ;
        endcase
    endtask

    task automatic wait_drained();
        do begin
            do @(posedge i_clk);
            while (cmd_q.size() != 0 || s_axis_tvalid || update_q.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (cmd_q.size() != 0 || s_axis_tvalid || update_q.size() != 0);
    endtask

    task automatic run_phase(input logic [mfbpw_pkg::DIM_W-1:0] w,
                             input logic [mfbpw_pkg::DIM_W-1:0] h,
                             input logic [1:0] rot, input logic rev, input int src_pct,
                             input int sink_pct, input int n_items, input bit squeeze);
        wait_drained();
        write_reg(mfbpw_pkg::CFG_WIDTH, w);
        write_reg(mfbpw_pkg::CFG_HEIGHT, h);
        write_reg(mfbpw_pkg::CFG_ROTATION, {8'd0, rot});
        write_reg(mfbpw_pkg::CFG_REVERSED, {9'd0, rev});
        i_cfg_valid <= 1'b0;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (n_items) cmd_q.push_back(random_cmd());
        if (squeeze) hold_requests++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                update_q.push_back(apply_cmd(cur_cmd));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    s_axis_tdata <= {5'd0, cur_cmd.fill, cur_cmd.color, cur_cmd.y, cur_cmd.x};
                    s_axis_tuser <= cur_cmd.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_upd.addr = m_axis_tdata[12:0];
                seen_upd.value = m_axis_tdata[20:13];
                seen_upd.written = m_axis_tuser;
                if (update_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected word: addr %0d value %02h written %0d",
                                 seen_upd.addr, seen_upd.value, seen_upd.written);
                    end
                end else begin
                    want_upd = update_q.pop_front();
                    if (seen_upd.addr !== want_upd.addr || seen_upd.value !== want_upd.value ||
                        seen_upd.written !== want_upd.written) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display({"mismatch: exp addr %0d value %02h written %0d, ",
                                      "got addr %0d value %02h written %0d"},
                                     want_upd.addr, want_upd.value, want_upd.written,
                                     seen_upd.addr, seen_upd.value, seen_upd.written);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (holds_taken != hold_requests) begin
                holds_taken++;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("mono_framebuffer_pixel_writer_top test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 28;
        sink_idle_pct = 47;
        // default panel 256 x 128, no rotation, normal polarity
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd0, 9'd0, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd0, 9'd7, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd0, 9'd0, 1'b0, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd1, 9'd0, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd255, 9'd127, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd256, 9'd5, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd10, 9'd128, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd511, 9'd511, 1'b1, 8'hff);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd255, 9'd0, 1'b0, 8'h00);
        push_cmd(OP_NONE, 9'd511, 9'd511, 1'b1, 8'hff);
        push_cmd(mfbpw_pkg::OP_FILL, 9'd0, 9'd0, 1'b0, 8'ha5);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd3, 9'd3, 1'b0, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd3, 9'd3, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd3, 9'd4, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd3, 9'd5, 1'b0, 8'h00);
        push_cmd(mfbpw_pkg::OP_CLEAR, 9'd511, 9'd511, 1'b1, 8'hff);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd128, 9'd64, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd170, 9'd85, 1'b1, 8'h00);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd85, 9'd170, 1'b0, 8'h00);
        push_cmd(mfbpw_pkg::OP_FILL, 9'd511, 9'd511, 1'b1, 8'hff);
        push_cmd(mfbpw_pkg::OP_PIXEL, 9'd200, 9'd100, 1'b0, 8'h00);
        push_cmd(OP_NONE, 9'd0, 9'd0, 1'b0, 8'h00);
        repeat (150) cmd_q.push_back(random_cmd());

        run_phase(10'd256, 10'd128, ROT_90, 1'b0, 28, 47, 170, 1'b0);
        run_phase(10'd128, 10'd64, ROT_180, 1'b1, 28, 47, 170, 1'b0);
        run_phase(10'd200, 10'd100, ROT_270, 1'b0, 47, 28, 170, 1'b0);
        run_phase(10'd512, 10'd512, ROT_0, 1'b1, 47, 28, 170, 1'b0);
        run_phase(10'd1023, 10'd1023, ROT_90, 1'b0, 47, 28, 170, 1'b0);
        run_phase(10'd0, 10'd64, ROT_180, 1'b0, 0, 0, 40, 1'b0);
        run_phase(10'd64, 10'd0, ROT_0, 1'b1, 0, 0, 40, 1'b0);
        run_phase(10'd8, 10'd8, ROT_270, 1'b1, 0, 0, 180, 1'b1);
        run_phase(10'd137, 10'd512, ROT_180, 1'b0, 0, 0, 180, 1'b0);
        wait_drained();

        if (mismatch_cnt == 0 && update_q.size() == 0) begin
            $display("mono_framebuffer_pixel_writer_top test passed");
        end else begin
            $display("mono_framebuffer_pixel_writer_top test failed");
        end
        $finish;
    end

endmodule
